[hdl/prgb_pkg.sv]
package prgb_pkg;

  localparam int IDX_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int WORD_W   = 16;
  localparam int FMT_W    = 4;
  localparam int APB_DW   = 32;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hff;

  localparam logic [WORD_W-1:0] RST_ALPHA_MASK = 16'h0000;
  localparam logic [WORD_W-1:0] RST_RED_MASK   = 16'hf800;
  localparam logic [WORD_W-1:0] RST_GREEN_MASK = 16'h07e0;
  localparam logic [WORD_W-1:0] RST_BLUE_MASK  = 16'h001f;

  localparam logic [REG_IDX_W-1:0] REG_ALPHA_MASK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RED_MASK    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_MASK  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_MASK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PASSTHROUGH = 3'd4;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  // decoded channel placement: shift left by pos, keep wid top bits
  typedef struct packed {
    logic [FMT_W-1:0] pos;
    logic [FMT_W-1:0] wid;
  } chan_fmt_t;

  typedef struct packed {
    chan_fmt_t alpha;
    chan_fmt_t red;
    chan_fmt_t green;
    chan_fmt_t blue;
    logic      passthrough;
  } fmt_cfg_t;

endpackage

[hdl/prgb_cfg.sv]
module prgb_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prgb_pkg::ADDR_W-1:0]    paddr,
  input  logic [prgb_pkg::APB_DW-1:0]    pwdata,
  output logic [prgb_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output prgb_pkg::fmt_cfg_t             fmt
);
  import prgb_pkg::*;

  logic [WORD_W-1:0]    alpha_mask_r;
  logic [WORD_W-1:0]    red_mask_r;
  logic [WORD_W-1:0]    green_mask_r;
  logic [WORD_W-1:0]    blue_mask_r;
  logic                 pass_r;
  fmt_cfg_t             fmt_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [WORD_W-1:0]    wr_mask;

  // position = trailing zeros, width = run of ones above, capped at CHAN_W
  function automatic chan_fmt_t decode_mask(input logic [WORD_W-1:0] mask);
    chan_fmt_t        f;
    logic             found;
    logic             run;
    logic [WORD_W-1:0] sh;
    f.pos = '0;
    f.wid = '0;
    found = 1'b0;
    run   = 1'b1;
    for (int i = 0; i < WORD_W; i++) begin
      if (!found && mask[i]) begin
        f.pos = FMT_W'(i);
        found = 1'b1;
      end
    end
    sh = mask >> f.pos;
    for (int i = 0; i < CHAN_W; i++) begin
      run = run & sh[i];
      if (run) begin
        f.wid = FMT_W'(i + 1);
      end
    end
    return f;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_mask = pwdata[WORD_W-1:0];
  assign fmt     = fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_mask_r      <= RST_ALPHA_MASK;
      red_mask_r        <= RST_RED_MASK;
      green_mask_r      <= RST_GREEN_MASK;
      blue_mask_r       <= RST_BLUE_MASK;
      pass_r            <= 1'b0;
      fmt_r.alpha       <= decode_mask(RST_ALPHA_MASK);
      fmt_r.red         <= decode_mask(RST_RED_MASK);
      fmt_r.green       <= decode_mask(RST_GREEN_MASK);
      fmt_r.blue        <= decode_mask(RST_BLUE_MASK);
      fmt_r.passthrough <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALPHA_MASK: begin
          alpha_mask_r <= wr_mask;
          fmt_r.alpha  <= decode_mask(wr_mask);
        end
        REG_RED_MASK: begin
          red_mask_r <= wr_mask;
          fmt_r.red  <= decode_mask(wr_mask);
        end
        REG_GREEN_MASK: begin
          green_mask_r <= wr_mask;
          fmt_r.green  <= decode_mask(wr_mask);
        end
        REG_BLUE_MASK: begin
          blue_mask_r <= wr_mask;
          fmt_r.blue  <= decode_mask(wr_mask);
        end
        REG_PASSTHROUGH: begin
          pass_r            <= pwdata[0];
          fmt_r.passthrough <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ALPHA_MASK:  prdata = APB_DW'(alpha_mask_r);
      REG_RED_MASK:    prdata = APB_DW'(red_mask_r);
      REG_GREEN_MASK:  prdata = APB_DW'(green_mask_r);
      REG_BLUE_MASK:   prdata = APB_DW'(blue_mask_r);
      REG_PASSTHROUGH: prdata = APB_DW'(pass_r);
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/prgb_pack.sv]
module prgb_pack (
  input  prgb_pkg::fmt_cfg_t                fmt,
  input  logic [prgb_pkg::IDX_W-1:0]        index,
  input  logic [prgb_pkg::CHAN_W-1:0]       red,
  input  logic [prgb_pkg::CHAN_W-1:0]       green,
  input  logic [prgb_pkg::CHAN_W-1:0]       blue,
  output logic [prgb_pkg::WORD_W-1:0]       word
);
  import prgb_pkg::*;

  localparam int TERM_W = CHAN_W + WORD_W;

  logic [CHAN_W-1:0] alpha;

  function automatic logic [WORD_W-1:0] place(input chan_fmt_t f,
                                              input logic [CHAN_W-1:0] val);
    logic [FMT_W-1:0]  rsh;
    logic [TERM_W-1:0] t;
    rsh = FMT_W'(CHAN_W) - f.wid;
    t   = TERM_W'(val >> rsh) << f.pos;
    return t[WORD_W-1:0];
  endfunction

  assign alpha = (index == '0) ? '0 : OPAQUE_ALPHA;

  // terms may overlap; sum wraps at 16 bits
  assign word = place(fmt.alpha, alpha) + place(fmt.red, red)
              + place(fmt.green, green) + place(fmt.blue, blue);

endmodule

[hdl/palette_to_packed_rgb_converter.sv]
// Palette-to-packed-RGB converter.
// Input channel (in_valid/in_ready): each beat is either a palette write
// (in_func = 0: in_index, in_red_in, in_green_in, in_blue_in) or a pixel
// lookup (in_func = 1: in_index). Writes pack the color by the channel masks
// into a 16-bit word and store it; they give no output beat.
// Output channel (out_valid/out_ready): one beat per pixel lookup, carrying
// the stored word (zero beyond the palette), or the raw index when passthrough is set.
// Config: APB registers alpha/red/green/blue mask and passthrough at byte
// offsets 0x0..0x10; write them only while no beats are in flight.
// Throughput: one beat per cycle while out_ready stays high. A pixel beat
// passes the input register, then the registered palette read, before it
// shows on out_*. Writes never stall and retire in the cycle after acceptance,
// so a lookup right behind a write to the same entry sees the new value.
// When out_ready is low with out_valid set, the output register holds; writes
// still retire, and in_ready drops once a pixel lookup waits in the input
// register. Reset clears the pipeline valids and sets the config registers to
// their reset masks; palette contents are undefined until written, never cleared.
module palette_to_packed_rgb_converter #(
  parameter int PALETTE_ENTRIES = prgb_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [prgb_pkg::IDX_W-1:0]    in_index,
  input  logic [prgb_pkg::CHAN_W-1:0]   in_red_in,
  input  logic [prgb_pkg::CHAN_W-1:0]   in_green_in,
  input  logic [prgb_pkg::CHAN_W-1:0]   in_blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prgb_pkg::WORD_W-1:0]   out_pixel_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prgb_pkg::ADDR_W-1:0]   paddr,
  input  logic [prgb_pkg::APB_DW-1:0]   pwdata,
  output logic [prgb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import prgb_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W:0] ENTRY_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);

  fmt_cfg_t          fmt;
  logic [WORD_W-1:0] pack_word;

  logic              a_vld_r;
  logic              a_vld_nxt;
  logic              a_func_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [CHAN_W-1:0] a_red_r;
  logic [CHAN_W-1:0] a_green_r;
  logic [CHAN_W-1:0] a_blue_r;
  logic              a_adv;
  logic              a_hit;
  logic [AW-1:0]     a_addr;

  logic              b_vld_r;
  logic              b_vld_nxt;
  logic [IDX_W-1:0]  b_idx_r;
  logic              b_hit_r;
  logic              b_free;
  logic              b_load;
  logic [WORD_W-1:0] rd_data_r;
  logic              in_fire;
  logic              mem_we;

  logic [WORD_W-1:0] palette_mem [PALETTE_ENTRIES];

  prgb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt     (fmt)
  );

  prgb_pack u_pack (
    .fmt   (fmt),
    .index (a_idx_r),
    .red   (a_red_r),
    .green (a_green_r),
    .blue  (a_blue_r),
    .word  (pack_word)
  );

  assign a_hit   = ({1'b0, a_idx_r} < ENTRY_LIM);
  assign a_addr  = a_idx_r[AW-1:0];
  assign b_free  = !b_vld_r || out_ready;
  assign a_adv   = a_vld_r && ((a_func_r == FUNC_WRITE) || b_free);
  assign b_load  = a_vld_r && (a_func_r == FUNC_PIXEL) && b_free;
  assign mem_we  = a_vld_r && (a_func_r == FUNC_WRITE) && a_hit;
  assign in_ready = !a_vld_r || a_adv;
  assign in_fire  = in_valid && in_ready;

  assign a_vld_nxt = in_fire ? 1'b1 : (a_adv ? 1'b0 : a_vld_r);
  assign b_vld_nxt = b_load ? 1'b1 : (out_ready ? 1'b0 : b_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_func_r  <= in_func;
      a_idx_r   <= in_index;
      a_red_r   <= in_red_in;
      a_green_r <= in_green_in;
      a_blue_r  <= in_blue_in;
    end
    if (b_load) begin
      b_idx_r <= a_idx_r;
      b_hit_r <= a_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[a_addr] <= pack_word;
    end
    if (b_load) begin
      rd_data_r <= palette_mem[a_addr];
    end
  end

  assign out_valid     = b_vld_r;
  assign out_pixel_out = fmt.passthrough ? WORD_W'(b_idx_r)
                       : (b_hit_r ? rd_data_r : '0);

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && (a_func_r == FUNC_WRITE)) |-> a_adv)
    else $error("palette write stalled");

  a_pixel_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_load |=> b_vld_r)
    else $error("pixel lookup lost between stages");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !a_adv) |-> (b_vld_r && !out_ready))
    else $error("input stage stalled without output backpressure");

endmodule
